>>> sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int BASE_W    = 64;
    localparam int EXP_IN_W  = 63;
    localparam int RESULT_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CNT_W     = $clog2(BASE_W + 1);

    localparam logic [CFG_W-1:0] RESET_MODULUS = 32'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SIGN,
        S_MUL,
        S_SQR
    } t_state;

endpackage

>>> sv/modular_exponentiation.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
// When the modulus is 0 or 1, o_valid follows start in the next cycle. One
// shared shift/add/reduce unit takes one multiplier bit per cycle; base
// reduction runs it over all 64 bits of the base magnitude.
// One item at a time; busy stays high until the result strobe.
// Reset (synchronous, active low) returns to idle and loads modulus 1000000007.
`timescale 1ns / 1ps

module modular_exponentiation #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [mexp_pkg::BASE_W-1:0]  i_base,
    input  logic [mexp_pkg::EXP_IN_W-1:0]       i_exponent,
    output logic                                o_valid,
    output logic [mexp_pkg::RESULT_W-1:0]       o_power_residue
);
    import mexp_pkg::*;

    localparam int SUM_W = MOD_WIDTH + 2;
    localparam int PAD_W = BASE_W - MOD_WIDTH;

    t_state                 r_state, n_state;
    logic [MOD_WIDTH-1:0]   r_modulus;
    logic [MOD_WIDTH-1:0]   r_rem, n_rem;
    logic [MOD_WIDTH-1:0]   r_acc, n_acc;
    logic [MOD_WIDTH-1:0]   r_sq, n_sq;
    logic [BASE_W-1:0]      r_bits, n_bits;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [EXP_WIDTH-1:0]   r_exp, n_exp;
    logic                   r_neg, n_neg;
    logic                   r_valid, n_valid;
    logic [MOD_WIDTH-1:0]   r_result, n_result;

    logic [MOD_WIDTH-1:0]   addend;
    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       m1;
    logic [SUM_W-1:0]       m2;
    logic [MOD_WIDTH-1:0]   step_rem;
    logic [MOD_WIDTH-1:0]   sign_rem;
    logic [BASE_W-1:0]      magnitude;
    logic [EXP_WIDTH-1:0]   exp_next;
    logic                   last_step;
    logic                   mod_trivial;

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_power_residue = RESULT_W'(r_result);
    assign mod_trivial     = (r_modulus[MOD_WIDTH-1:1] == '0);
    assign magnitude       = i_base[BASE_W-1] ? (BASE_W'(0) - BASE_W'(i_base))
                                              : BASE_W'(i_base);
    assign last_step       = (r_cnt == CNT_W'(1));
    assign exp_next        = r_exp >> 1;

    // shared unit: rem = (2*rem + bit*addend) mod m
    always_comb begin
        case (r_state)
            S_MUL:   addend = r_acc;
            S_SQR:   addend = r_sq;
            default: addend = MOD_WIDTH'(1);
        endcase
        sum = {1'b0, r_rem, 1'b0} + (r_bits[BASE_W-1] ? SUM_W'(addend) : SUM_W'(0));
        m1  = SUM_W'(r_modulus);
        m2  = {1'b0, r_modulus, 1'b0};
        if (sum >= m2) begin
            step_rem = MOD_WIDTH'(sum - m2);
        end else if (sum >= m1) begin
            step_rem = MOD_WIDTH'(sum - m1);
        end else begin
            step_rem = MOD_WIDTH'(sum);
        end
        sign_rem = (r_neg && (r_rem != '0)) ? (r_modulus - r_rem) : r_rem;
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_sq     = r_sq;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_neg    = r_neg;
        n_valid  = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (mod_trivial) begin
                        n_valid  = 1'b1;
                        n_result = '0;
                    end else begin
                        n_state = S_BASE;
                        n_rem   = '0;
                        n_acc   = MOD_WIDTH'(1);
                        n_bits  = magnitude;
                        n_cnt   = CNT_W'(BASE_W);
                        n_exp   = i_exponent[EXP_WIDTH-1:0];
                        n_neg   = i_base[BASE_W-1];
                    end
                end
            end
            S_BASE: begin
                n_rem  = step_rem;
                n_bits = r_bits << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                n_sq   = sign_rem;
                n_rem  = '0;
                n_bits = {sign_rem, PAD_W'(0)};
                n_cnt  = CNT_W'(MOD_WIDTH);
                if (r_exp == '0) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_result = r_acc;
                end else if (r_exp[0]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                n_rem  = step_rem;
                n_bits = r_bits << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step) begin
                    n_acc  = step_rem;
                    n_rem  = '0;
                    n_bits = {r_sq, PAD_W'(0)};
                    n_cnt  = CNT_W'(MOD_WIDTH);
                    if (exp_next == '0) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_result = step_rem;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                n_rem  = step_rem;
                n_bits = r_bits << 1;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last_step) begin
                    n_sq   = step_rem;
                    n_exp  = exp_next;
                    n_rem  = '0;
                    n_bits = {step_rem, PAD_W'(0)};
                    n_cnt  = CNT_W'(MOD_WIDTH);
                    if (exp_next == '0) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_result = r_acc;
                    end else if (exp_next[0]) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_modulus <= MOD_WIDTH'(RESET_MODULUS);
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata[MOD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_bits   <= n_bits;
        r_cnt    <= n_cnt;
        r_exp    <= n_exp;
        r_neg    <= n_neg;
        r_result <= n_result;
    end

endmodule

>>> sv/mexp_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
`timescale 1ns / 1ps

module mexp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transfer neither busy nor answered");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result strobe without an item in flight");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

>>> bench/mexp_checker.sv
// Scoreboard for the modular exponentiation block: tracks the modulus, predicts residues.
`timescale 1ns / 1ps

module mexp_scoreboard #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [mexp_pkg::BASE_W-1:0]         i_base,
    input  logic [mexp_pkg::EXP_IN_W-1:0]       i_exponent,
    input  logic                                i_valid,
    input  logic [mexp_pkg::RESULT_W-1:0]       i_power_residue,
    output int                                  o_mismatches,
    output int                                  o_pending
);

    localparam logic [mexp_pkg::CFG_W-1:0] MOD_MASK =
        mexp_pkg::CFG_W'((64'd1 << MOD_WIDTH) - 64'd1);

    typedef struct {
        logic [mexp_pkg::BASE_W-1:0]   base;
        logic [mexp_pkg::EXP_IN_W-1:0] exponent;
        logic [mexp_pkg::RESULT_W-1:0] residue;
    } t_power_job;

    logic [mexp_pkg::CFG_W-1:0] modulus_r;
    t_power_job                 residue_q[$];

    function automatic logic [mexp_pkg::RESULT_W-1:0] mod_power(
        input logic [63:0]                   b,
        input logic [mexp_pkg::EXP_IN_W-1:0] e,
        input logic [mexp_pkg::CFG_W-1:0]    m
    );
        logic [63:0] mw;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] rem;
        if (m <= 1)
            return '0;
        mw = {32'd0, m};
        if (!b[63]) begin
            sq = b % mw;
        end else begin
            rem = (64'd0 - b) % mw;
            sq  = (rem == 0) ? 64'd0 : mw - rem;
        end
        acc = 64'd1;
        for (int i = 0; i < EXP_WIDTH; i++) begin
            if (e[i])
                acc = (acc * sq) % mw;
            sq = (sq * sq) % mw;
        end
        return acc[mexp_pkg::RESULT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_power_job job;
        if (!i_rst_n) begin
            modulus_r    = mexp_pkg::RESET_MODULUS & MOD_MASK;
            o_mismatches = 0;
            residue_q.delete();
        end else begin
            if (i_valid) begin
                if (residue_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected residue %0d", $time, i_power_residue);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    job = residue_q.pop_front();
                    if (i_power_residue !== job.residue) begin
                        if (o_mismatches < 10)
                            $display("%0t: base %0d exponent %0d modulus %0d: %s %0d, got %0d",
                                     $time, $signed(job.base), job.exponent, modulus_r,
                                     "expected", job.residue, i_power_residue);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                job.base     = i_base;
                job.exponent = i_exponent;
                job.residue  = mod_power(i_base, i_exponent, modulus_r);
                residue_q    = {residue_q, job};
            end
            if (i_cfg_we)
                modulus_r = i_cfg_wdata & MOD_MASK;
        end
        o_pending = residue_q.size();
    end

endmodule

>>> bench/tb_top.sv
// Testbench top: stimulus, modulus settings, watchdog and verdict for modular exponentiation.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [63:0] BASE_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BASE_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] BASE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] EXP_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [mexp_pkg::CFG_W-1:0]          i_cfg_wdata;
    logic                                start;
    logic                                busy;
    logic signed [mexp_pkg::BASE_W-1:0]  i_base;
    logic [mexp_pkg::EXP_IN_W-1:0]       i_exponent;
    logic                                o_valid;
    logic [mexp_pkg::RESULT_W-1:0]       o_power_residue;

    int mismatches;
    int pending;
    int idle_cycles;

    modular_exponentiation DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_base          (i_base),
        .i_exponent      (i_exponent),
        .o_valid         (o_valid),
        .o_power_residue (o_power_residue)
    );

    mexp_scoreboard u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (start),
        .i_busy          (busy),
        .i_base          (i_base),
        .i_exponent      (i_exponent),
        .i_valid         (o_valid),
        .i_power_residue (o_power_residue),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("modular_exponentiation: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue(input logic [63:0] b, input logic [62:0] e);
        start      <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] random_base();
        logic [31:0] pick;
        if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 40);
            return {32'd0, pick} - 64'd20;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [62:0] random_exponent();
        int sel;
        logic [63:0] wide;
        sel = $urandom_range(0, 19);
        if (sel < 3) begin
            wide = {$urandom, $urandom};
            return wide[62:0];
        end
        if (sel < 8)
            return {31'd0, $urandom};
        return 63'($urandom_range(0, 1023));
    endfunction

    task automatic run_random(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            if (burst > left)
                burst = left;
            repeat (burst) issue(random_base(), random_exponent());
            left -= burst;
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 3000);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] value, input int count);
        write_modulus(value);
        issue(BASE_ONES, 63'd0);
        issue(BASE_MIN, EXP_MAX);
        run_random(count);
        drain();
    endtask

    logic [63:0] dir_base[18];
    logic [62:0] dir_exp[18];

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_base      = '0;
        i_exponent  = '0;

        dir_base = '{64'd0, 64'd0, 64'd1, BASE_ONES, BASE_ONES, BASE_ONES, BASE_ONES,
                     BASE_MAX, BASE_MIN, BASE_MIN, 64'd1000000007, -64'd1000000007,
                     -64'd2, 64'd2, 64'd3, 64'd123456789, -64'd987654321, 64'd1000000006};
        dir_exp  = '{63'd0, 63'd1, EXP_MAX, 63'd0, 63'd1, 63'd2, EXP_MAX,
                     63'd1, 63'd1, 63'd2, 63'd3, 63'd5,
                     63'h4000_0000_0000_0000, 63'd62, 63'd1000000005,
                     63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 63'd2};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_base[k])
            issue(dir_base[k], dir_exp[k]);
        drain();

        run_phase(32'hFFFF_FFFF, 18);
        run_phase(32'd1, 6);
        run_phase(32'd0, 6);
        run_phase(32'd2, 10);
        run_phase(32'hFFFF_FFFB, 18);
        run_phase(32'($urandom_range(3, 255)), 15);
        run_phase($urandom, 18);
        run_phase(32'd1000000007, 15);

        repeat (16) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule
